// ----- sv/chip8_instruction_execute_assert.svh -----
// Assertion macros used by the CHIP-8 execute unit back end (c8x_exec).
// No dependencies.
`ifndef CHIP8_INSTRUCTION_EXECUTE_ASSERT_SVH
`define CHIP8_INSTRUCTION_EXECUTE_ASSERT_SVH
// Implication checked every cycle outside reset
`define C8_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset
`define C8_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

// ----- sv/c8x_pkg.sv -----
// Package for the CHIP-8 execute unit: payload structs, codes, constants.
// No dependencies.
package c8x_pkg;
   typedef struct packed {
      logic        kind;
      logic [15:0] instruction;
      logic [15:0] key_mask;
      logic [7:0]  random_byte;
   } req_type;

   typedef struct packed {
      logic        mem_write;
      logic [11:0] mem_addr;
      logic [7:0]  mem_data;
      logic [11:0] next_pc;
      logic        clear_screen;
      logic        waiting_for_key;
      logic [1:0]  fault;
      logic        last;
   } rsp_type;

   localparam logic [1:0] FAULT_NONE  = 2'd0;
   localparam logic [1:0] FAULT_FULL  = 2'd1;
   localparam logic [1:0] FAULT_EMPTY = 2'd2;
   localparam logic [1:0] FAULT_UNDEF = 2'd3;

   localparam logic [7:0] NN_CLS  = 8'hE0;
   localparam logic [7:0] NN_RET  = 8'hEE;
   localparam logic [7:0] NN_SKP  = 8'h9E;
   localparam logic [7:0] NN_SKNP = 8'hA1;
   localparam logic [7:0] NN_GDT  = 8'h07;
   localparam logic [7:0] NN_WAIT = 8'h0A;
   localparam logic [7:0] NN_SDT  = 8'h15;
   localparam logic [7:0] NN_SST  = 8'h18;
   localparam logic [7:0] NN_ADDI = 8'h1E;
   localparam logic [7:0] NN_FONT = 8'h29;
   localparam logic [7:0] NN_BCD  = 8'h33;
   localparam logic [7:0] NN_DUMP = 8'h55;
   localparam logic [3:0] REG_F   = 4'hF;
   localparam logic [11:0] FONT_RESET = 12'd80;
   localparam logic [11:0] PC_RESET   = 12'd512;
   localparam logic [1:0] QUEUE_DEPTH_LOG = 2'd2;

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_EMIT} exec_state_type;

   // Queue status: full and empty flags
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;
endpackage

// ----- sv/c8x_queue.sv -----
// Short FIFO that decouples the front end from the execute sequencer.
// Depends on c8x_pkg.
module c8x_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  c8x_pkg::req_type push_data,
   input  logic             pop,
   output c8x_pkg::req_type pop_data,
   output c8x_pkg::queue_status_type status
);
   import c8x_pkg::*;

   req_type    mem_ff [4];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + 2'd1 : wr_ff;
      rd_in  = pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + {2'd0, push} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   assign pop_data     = mem_ff[rd_ff];
   assign status.full  = cnt_ff[2];
   assign status.empty = (cnt_ff == 3'd0);
endmodule

// ----- sv/c8x_exec.sv -----
// Back end: executes one queued item, emits its results one per cycle unless rsp_stall holds them.
// Depends on c8x_pkg and the assertion header.
`include "chip8_instruction_execute_assert.svh"
module c8x_exec #(
   parameter int STACK_ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [11:0]      font_base,
   input  logic             item_valid,
   input  c8x_pkg::req_type item,
   output logic             item_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output c8x_pkg::rsp_type rsp_data
);
   import c8x_pkg::*;
   localparam int SW = $clog2(STACK_ENTRIES);
   localparam int CW = $clog2(STACK_ENTRIES + 1);

   exec_state_type state_ff, state_in;
   logic [7:0]  v_ff [16];
   logic [11:0] stk_ff [STACK_ENTRIES];
   logic [11:0] top_ff;
   logic [15:0] i_ff;
   logic [11:0] pc_ff;
   logic [CW-1:0] sp_ff;
   logic [7:0]  dt_ff, st_ff;
   // emit state
   logic [3:0]  cnt_ff, cnt_in, k_ff;
   logic        bcd_ff;
   logic [7:0]  d0_ff, d1_ff, d2_ff;
   logic [1:0]  flt_ff;
   logic        clr_ff, wt_ff;
   logic        mem_ff;

   logic [3:0] op, x, y, n;
   logic [7:0] nn, vx, vy;
   logic [11:0] nnn;
   assign op  = item.instruction[15:12];
   assign x   = item.instruction[11:8];
   assign y   = item.instruction[7:4];
   assign n   = item.instruction[3:0];
   assign nn  = item.instruction[7:0];
   assign nnn = item.instruction[11:0];
   assign vx  = v_ff[x];
   assign vy  = v_ff[y];

   logic go, emit_done;
   assign go        = (state_ff == ST_IDLE) && item_valid;
   assign emit_done = (state_ff == ST_EMIT) && !rsp_stall && (k_ff == cnt_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (go) state_in = ST_EXEC;
         ST_EXEC: state_in = ST_EMIT;
         ST_EMIT: if (emit_done) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      item_pop  = (state_ff == ST_EXEC);
      rsp_valid = (state_ff == ST_EMIT);
   end

   // execute decode
   logic [11:0] npc;
   logic [1:0]  flt;
   logic        clr, wt, wr_x, wr_f, bcd, mem;
   logic [7:0]  x_val, f_val;
   logic [8:0]  sum;
   logic        kp;
   logic [3:0]  cnt;

   always_comb begin
      npc = pc_ff + 12'd2; flt = FAULT_NONE; clr = 1'b0; wt = 1'b0;
      wr_x = 1'b0; wr_f = 1'b0; x_val = '0; f_val = '0; bcd = 1'b0; mem = 1'b0;
      cnt = 4'd0;
      sum = {1'b0, vx} + {1'b0, vy};
      kp = item.key_mask[vx[3:0]] && (vx[7:4] == 4'd0);
      if (item.kind) begin
         npc = pc_ff;
      end else begin
         case (op)
            4'h0: begin
               if (nn == NN_CLS) clr = 1'b1;
               else if (nn == NN_RET) begin
                  if (sp_ff != '0) npc = top_ff;
                  else flt = FAULT_EMPTY;
               end else flt = FAULT_UNDEF;
            end
            4'h1: npc = nnn;
            4'h2: begin
               if (sp_ff < CW'(STACK_ENTRIES)) npc = nnn;
               else flt = FAULT_FULL;
            end
            4'h3: if (vx == nn) npc = pc_ff + 12'd4;
            4'h4: if (vx != nn) npc = pc_ff + 12'd4;
            4'h5: if (vx == vy) npc = pc_ff + 12'd4;
            4'h9: if (vx != vy) npc = pc_ff + 12'd4;
            4'h6: begin wr_x = 1'b1; x_val = nn; end
            4'h7: begin wr_x = 1'b1; x_val = vx + nn; end
            4'h8: begin
               wr_x = 1'b1;
               case (n)
                  4'h0: x_val = vy;
                  4'h1: x_val = vx | vy;
                  4'h2: x_val = vx & vy;
                  4'h3: x_val = vx ^ vy;
                  4'h4: begin x_val = sum[7:0]; wr_f = 1'b1; f_val = {7'd0, sum[8]}; end
                  4'h5: begin x_val = vx - vy; wr_f = 1'b1; f_val = {7'd0, vx >= vy}; end
                  4'h7: begin x_val = vy - vx; wr_f = 1'b1; f_val = {7'd0, vy >= vx}; end
                  4'h6: begin x_val = {1'b0, vy[7:1]}; wr_f = 1'b1; f_val = {7'd0, vy[0]}; end
                  4'hE: begin x_val = {vy[6:0], 1'b0}; wr_f = 1'b1; f_val = {7'd0, vy[7]}; end
                  default: begin wr_x = 1'b0; flt = FAULT_UNDEF; end
               endcase
            end
            4'hA: ;
            4'hB: npc = {4'd0, v_ff[0]} + nnn;
            4'hC: begin wr_x = 1'b1; x_val = item.random_byte & nn; end
            4'hE: begin
               if (nn == NN_SKP) begin if (kp) npc = pc_ff + 12'd4; end
               else if (nn == NN_SKNP) begin if (!kp) npc = pc_ff + 12'd4; end
               else flt = FAULT_UNDEF;
            end
            4'hF: begin
               case (nn)
                  NN_GDT:  begin wr_x = 1'b1; x_val = dt_ff; end
                  NN_SDT, NN_SST, NN_ADDI, NN_FONT: ;
                  NN_WAIT: wt = 1'b1;
                  NN_BCD:  begin mem = 1'b1; bcd = 1'b1; cnt = 4'd2; end
                  NN_DUMP: begin mem = 1'b1; cnt = x; end
                  default: flt = FAULT_UNDEF;
               endcase
            end
            default: flt = FAULT_UNDEF;
         endcase
      end
   end

   // BCD digits by compare-subtract
   logic [7:0] h, r1, t, o;
   always_comb begin
      h  = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
      r1 = vx - h * 8'd100;
      t  = 8'd0; o = r1;
      for (int j = 9; j >= 1; j--) begin
         if (t == 8'd0 && r1 >= 8'(j * 10)) begin t = 8'(j); o = r1 - 8'(j * 10); end
      end
   end

   logic fx;
   assign fx = (state_ff == ST_EXEC) && !item.kind && (op == 4'hF);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int j = 0; j < 16; j++) v_ff[j] <= '0;
         i_ff <= '0; pc_ff <= PC_RESET; sp_ff <= '0; dt_ff <= '0; st_ff <= '0;
         k_ff <= '0; cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_EXEC) begin
            pc_ff <= npc;
            cnt_ff <= cnt_in;
            k_ff <= '0;
            if (item.kind) begin
               if (dt_ff != '0) dt_ff <= dt_ff - 8'd1;
               if (st_ff != '0) st_ff <= st_ff - 8'd1;
            end else begin
               // VF is written last when x is F
               if (wr_x && !(wr_f && x == REG_F)) v_ff[x] <= x_val;
               if (wr_f) v_ff[REG_F] <= f_val;
               if (op == 4'hA) i_ff <= {4'd0, nnn};
               if (op == 4'h2 && flt == FAULT_NONE) sp_ff <= sp_ff + CW'(1);
               if (op == 4'h0 && nn == NN_RET && flt == FAULT_NONE)
                  sp_ff <= sp_ff - CW'(1);
               if (fx && nn == NN_SDT) dt_ff <= vx;
               if (fx && nn == NN_SST) st_ff <= vx;
               if (fx && nn == NN_ADDI) i_ff <= i_ff + {8'd0, vx};
               if (fx && nn == NN_FONT)
                  i_ff <= {4'd0, font_base} + {6'd0, vx, 2'd0} + {8'd0, vx};
            end
         end else if (state_ff == ST_EMIT && !rsp_stall && k_ff != cnt_ff) begin
            k_ff <= k_ff + 4'd1;
         end
      end
   end

   assign cnt_in = cnt;

   always_ff @(posedge clock) begin
      // stack pointer only moves in execute, so the idle cycle prefetches the top
      top_ff <= stk_ff[SW'(sp_ff - CW'(1))];
      if (state_ff == ST_EXEC) begin
         if (!item.kind && op == 4'h2 && flt == FAULT_NONE)
            stk_ff[SW'(sp_ff)] <= pc_ff + 12'd2;
         bcd_ff <= bcd; d0_ff <= h; d1_ff <= t; d2_ff <= o;
         flt_ff <= flt; clr_ff <= clr; wt_ff <= wt;
         mem_ff <= mem;
      end
   end

   always_comb begin
      rsp_data.mem_write       = mem_ff;
      rsp_data.mem_addr        = mem_ff ? i_ff[11:0] + {8'd0, k_ff} : 12'd0;
      if (!mem_ff) rsp_data.mem_data = 8'd0;
      else if (bcd_ff) rsp_data.mem_data = (k_ff == 4'd0) ? d0_ff :
                                           (k_ff == 4'd1) ? d1_ff : d2_ff;
      else rsp_data.mem_data = v_ff[k_ff];
      rsp_data.next_pc         = pc_ff;
      rsp_data.clear_screen    = clr_ff;
      rsp_data.waiting_for_key = wt_ff;
      rsp_data.fault           = flt_ff;
      rsp_data.last            = (k_ff == cnt_ff);
   end

   `C8_ASSERT_IMP(a_pop_has_item, clock, reset, item_pop, item_valid)
   `C8_ASSERT_IMP(a_k_bound, clock, reset, rsp_valid, k_ff <= cnt_ff)
   `C8_ASSERT_NXT(a_done_idle, clock, reset, emit_done, state_ff == ST_IDLE)
   `C8_ASSERT_IMP(a_sp_bound, clock, reset, 1'b1, sp_ff <= CW'(STACK_ENTRIES))
endmodule

// ----- sv/chip8_instruction_execute.sv -----
// Top level of the CHIP-8 execute unit: front queue and execute back end.
// Depends on c8x_pkg, c8x_queue, c8x_exec.
//
//   port group   dir   handshake        payload
//   req_         in    valid / stall    c8x_pkg::req_type
//   rsp_         out   valid / stall    c8x_pkg::rsp_type
//   csr_         in    valid / ready    font_base, 12 bits
//
// An item is decoded and executed in the sequencer's execute state, then its results are
// emitted in order (1, 3 for BCD, x+1 for a register dump); the execute sequencer sets this.
// The queue holds four items; req_stall rises when it is full.
// Reset is synchronous; it restores registers, PC 512 and font base 80.
// A stalled result holds; the queue keeps accepting items meanwhile.
module chip8_instruction_execute #(
   parameter int STACK_ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  c8x_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output c8x_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [11:0]      csr_data
);
   import c8x_pkg::*;

   logic [11:0] font_ff;
   req_type q_data;
   queue_status_type q_st;
   logic pop;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) font_ff <= FONT_RESET;
      else if (csr_valid) font_ff <= csr_data;
   end

   assign req_stall = q_st.full;

   c8x_queue u_queue (
      .clock(clock), .reset(reset),
      .push(req_valid && !q_st.full), .push_data(req_data),
      .pop(pop), .pop_data(q_data), .status(q_st)
   );

   c8x_exec #(.STACK_ENTRIES(STACK_ENTRIES)) u_exec (
      .clock(clock), .reset(reset), .font_base(font_ff),
      .item_valid(!q_st.empty), .item(q_data), .item_pop(pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );
endmodule
